/* hdl/nec_ir_pkg.sv */
// nec_ir_pkg: shared types and constants for the nec infrared edge interval decoder
// register map, reset values and frame layout; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nec_ir_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int FRAME_BITS      = 32;
    localparam int BIT_IDX_WIDTH   = $clog2(FRAME_BITS);
    localparam int BYTE_WIDTH      = 8;

    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_WIDTH   = $clog2(NUM_REGS);
    localparam int APB_ADDR_WIDTH  = REG_IDX_WIDTH + 2;
    localparam int APB_DATA_WIDTH  = 32;

    typedef logic [REG_IDX_WIDTH-1:0] t_reg_idx;
    typedef logic [CFG_WIDTH-1:0]     t_cfg_word;
    typedef t_cfg_word                t_cfg_array [NUM_REGS];
    typedef logic [BYTE_WIDTH-1:0]    t_byte;

    localparam t_reg_idx REG_HDR      = 3'd0;
    localparam t_reg_idx REG_HDR_TOL  = 3'd1;
    localparam t_reg_idx REG_ONE      = 3'd2;
    localparam t_reg_idx REG_ONE_TOL  = 3'd3;
    localparam t_reg_idx REG_ZERO     = 3'd4;
    localparam t_reg_idx REG_ZERO_TOL = 3'd5;
    localparam t_reg_idx REG_RPT      = 3'd6;
    localparam t_reg_idx REG_RPT_TOL  = 3'd7;

    localparam t_cfg_array CFG_RESET = '{
        16'd13500, 16'd2000, 16'd2250, 16'd500,
        16'd1120,  16'd300,  16'd11750, 16'd2000
    };

    localparam t_byte BYTE_ALL_ONES = 8'hFF;

endpackage : nec_ir_pkg

`default_nettype wire

/* hdl/nec_ir_ifs.sv */
// nec_ir_cap_if and nec_ir_res_if: valid/ready channels of the decoder
// capture word in, decoded result word out; depends on nec_ir_pkg
`timescale 1ns / 1ps
`default_nettype none

interface nec_ir_cap_if #(
    parameter int TIMER_WIDTH = nec_ir_pkg::TIMER_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [TIMER_WIDTH-1:0] capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface : nec_ir_cap_if

interface nec_ir_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] address;
    logic [7:0] command;
    logic       is_repeat;

    modport source (output valid, output address, output command, output is_repeat,
                    input ready);
    modport sink   (input valid, input address, input command, input is_repeat,
                    output ready);
endinterface : nec_ir_res_if

`default_nettype wire

/* hdl/nec_ir_window.sv */
// nec_ir_window: checks an interval against nominal +/- tolerance, exclusive
// exact absolute difference, no wrap; depends on nec_ir_pkg
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_window #(
    parameter int TIMER_WIDTH = nec_ir_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic [TIMER_WIDTH-1:0]           i_interval,
    input  wire nec_ir_pkg::t_cfg_word            i_nominal,
    input  wire nec_ir_pkg::t_cfg_word            i_tolerance,
    output logic                                  o_match
);
    import nec_ir_pkg::*;

    localparam int W = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

    logic [W-1:0] iv_ext;
    logic [W-1:0] nom_ext;
    logic [W-1:0] tol_ext;
    logic [W-1:0] diff;

    always_comb begin
        iv_ext  = W'(i_interval);
        nom_ext = W'(i_nominal);
        tol_ext = W'(i_tolerance);
        diff    = (iv_ext >= nom_ext) ? (iv_ext - nom_ext) : (nom_ext - iv_ext);
        o_match = (diff < tol_ext);
    end

endmodule : nec_ir_window

`default_nettype wire

/* hdl/nec_ir_edge_interval_decoder.sv */
// nec_ir_edge_interval_decoder: top level, apb registers, input and result registers
// depends on nec_ir_pkg, nec_ir_ifs (nec_ir_cap_if, nec_ir_res_if), nec_ir_window
`timescale 1ns / 1ps
`default_nettype none

// Decodes NEC infrared frames from timer values captured at each falling edge
// of the receiver. Each capture word is latched in an input register, where
// its interval to the previous capture is matched against the header, one,
// zero and repeat windows set over APB (register i at byte 4*i, 16 bits
// each, window is |interval - nominal| < tolerance). A result word is
// registered as its capture leaves the input register: a good frame after
// its 32nd bit, or a repeat carrying the last frame's address and command.
// One capture word is taken every cycle; the input stalls only while a result
// is waiting in the output register and the next decode also has a result.

module nec_ir_edge_interval_decoder #(
    parameter int TIMER_WIDTH = nec_ir_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    nec_ir_cap_if.sink                                i_cap,
    nec_ir_res_if.source                              o_res,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [nec_ir_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [nec_ir_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [nec_ir_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                      pready
);
    import nec_ir_pkg::*;

    // configuration registers
    t_cfg_word r_cfg [NUM_REGS];
    t_reg_idx  reg_idx;
    logic      cfg_wr;

    assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = APB_DATA_WIDTH'(r_cfg[reg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= CFG_RESET[k];
            end
        end else if (cfg_wr) begin
            r_cfg[reg_idx] <= pwdata[CFG_WIDTH-1:0];
        end
    end

    // input register
    logic                   r_in_valid;
    logic [TIMER_WIDTH-1:0] r_in_time;
    logic                   adv;
    logic                   has_result;
    logic                   out_free;

    assign out_free    = !o_res.valid || o_res.ready;
    assign adv         = r_in_valid && (!has_result || out_free);
    assign i_cap.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cap.ready) begin
            r_in_valid <= i_cap.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cap.valid && i_cap.ready) begin
            r_in_time <= i_cap.capture_time;
        end
    end

    // decoder state
    logic [TIMER_WIDTH-1:0]   r_prev;
    logic                     r_in_frame;
    logic [BIT_IDX_WIDTH-1:0] r_bit_idx;
    logic [FRAME_BITS-1:0]    r_word;
    t_byte                    r_last_addr;
    t_byte                    r_last_cmd;

    logic [TIMER_WIDTH-1:0] interval;
    logic                   m_hdr, m_one, m_zero, m_rpt;

    assign interval = r_in_time - r_prev;

    nec_ir_window #(.TIMER_WIDTH(TIMER_WIDTH)) u_win_hdr (
        .i_interval(interval), .i_nominal(r_cfg[REG_HDR]),
        .i_tolerance(r_cfg[REG_HDR_TOL]), .o_match(m_hdr)
    );
    nec_ir_window #(.TIMER_WIDTH(TIMER_WIDTH)) u_win_one (
        .i_interval(interval), .i_nominal(r_cfg[REG_ONE]),
        .i_tolerance(r_cfg[REG_ONE_TOL]), .o_match(m_one)
    );
    nec_ir_window #(.TIMER_WIDTH(TIMER_WIDTH)) u_win_zero (
        .i_interval(interval), .i_nominal(r_cfg[REG_ZERO]),
        .i_tolerance(r_cfg[REG_ZERO_TOL]), .o_match(m_zero)
    );
    nec_ir_window #(.TIMER_WIDTH(TIMER_WIDTH)) u_win_rpt (
        .i_interval(interval), .i_nominal(r_cfg[REG_RPT]),
        .i_tolerance(r_cfg[REG_RPT_TOL]), .o_match(m_rpt)
    );

    logic                     n_in_frame;
    logic [BIT_IDX_WIDTH-1:0] n_bit_idx;
    logic [FRAME_BITS-1:0]    n_word;
    t_byte                    n_last_addr;
    t_byte                    n_last_cmd;
    t_byte                    n_out_addr;
    t_byte                    n_out_cmd;
    logic                     n_out_rpt;
    logic [FRAME_BITS-1:0]    bit_mask;
    logic [BYTE_WIDTH:0]      addr_sum;
    logic [BYTE_WIDTH:0]      cmd_sum;

    always_comb begin
        n_in_frame  = r_in_frame;
        n_bit_idx   = r_bit_idx;
        n_word      = r_word;
        n_last_addr = r_last_addr;
        n_last_cmd  = r_last_cmd;
        n_out_addr  = r_last_addr;
        n_out_cmd   = r_last_cmd;
        n_out_rpt   = 1'b1;
        has_result  = 1'b0;
        bit_mask    = FRAME_BITS'(1) << r_bit_idx;
        addr_sum    = '0;
        cmd_sum     = '0;

        if (!r_in_frame) begin
            n_in_frame = m_hdr;
        end else if (m_one || m_zero) begin
            n_word = m_one ? (r_word | bit_mask) : (r_word & ~bit_mask);
            if (r_bit_idx == BIT_IDX_WIDTH'(FRAME_BITS - 1)) begin
                // frame complete: bytes are address, ~address, command, ~command
                n_last_addr = n_word[7:0];
                n_last_cmd  = n_word[23:16];
                n_in_frame  = 1'b0;
                n_bit_idx   = '0;
                addr_sum    = {1'b0, n_word[7:0]} + {1'b0, n_word[15:8]};
                cmd_sum     = {1'b0, n_word[23:16]} + {1'b0, n_word[31:24]};
                n_out_addr  = n_word[7:0];
                n_out_cmd   = n_word[23:16];
                n_out_rpt   = 1'b0;
                has_result  = (addr_sum == {1'b0, BYTE_ALL_ONES})
                           && (cmd_sum == {1'b0, BYTE_ALL_ONES});
            end else begin
                n_bit_idx = r_bit_idx + 1'b1;
            end
        end else if (m_rpt) begin
            n_in_frame = 1'b0;
            n_bit_idx  = '0;
            has_result = 1'b1;
        end else begin
            // bad interval aborts the frame
            n_in_frame = 1'b0;
            n_bit_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_in_frame  <= 1'b0;
            r_bit_idx   <= '0;
            r_word      <= '0;
            r_last_addr <= '0;
            r_last_cmd  <= '0;
        end else if (adv) begin
            r_prev      <= r_in_time;
            r_in_frame  <= n_in_frame;
            r_bit_idx   <= n_bit_idx;
            r_word      <= n_word;
            r_last_addr <= n_last_addr;
            r_last_cmd  <= n_last_cmd;
        end
    end

    // result register
    logic  r_out_valid;
    t_byte r_out_addr;
    t_byte r_out_cmd;
    logic  r_out_rpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && has_result) begin
            r_out_addr <= n_out_addr;
            r_out_cmd  <= n_out_cmd;
            r_out_rpt  <= n_out_rpt;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.address   = r_out_addr;
    assign o_res.command   = r_out_cmd;
    assign o_res.is_repeat = r_out_rpt;

endmodule : nec_ir_edge_interval_decoder

`default_nettype wire

/* verif/nec_ir_edge_interval_decoder_tb.sv */
// testbench for nec_ir_edge_interval_decoder: random edge timestamps, scoreboard checking
// of every decoded word; depends on nec_ir_pkg, nec_ir_ifs and the decoder rtl
`timescale 1ns / 1ps

module nec_ir_edge_interval_decoder_tb;
    import nec_ir_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_TICKS    = 65535;

    typedef struct packed {
        t_byte address;
        t_byte command;
        logic  is_repeat;
    } nec_result_t;

    // tracks the decoder state and queues the words it should produce
    class nec_frame_scoreboard;
        t_cfg_array               windows;
        logic [15:0]              prev_capture;
        logic                     in_frame;
        logic [BIT_IDX_WIDTH-1:0] bit_index;
        logic [31:0]              frame_word;
        t_byte                    last_address;
        t_byte                    last_command;
        nec_result_t              expected_words [$];
        int                       mismatches;
        int                       frames_seen;
        int                       repeats_seen;
        int                       edges_seen;

        function new();
            windows      = CFG_RESET;
            prev_capture = '0;
            in_frame     = 1'b0;
            bit_index    = '0;
            frame_word   = '0;
            last_address = '0;
            last_command = '0;
            mismatches   = 0;
            frames_seen  = 0;
            repeats_seen = 0;
            edges_seen   = 0;
        endfunction

        function void set_window(t_reg_idx idx, t_cfg_word value);
            windows[idx] = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // strict window: |t - nominal| < tolerance
        function bit in_window(int t, int nominal, int tol);
            int diff;
            diff = (t >= nominal) ? t - nominal : nominal - t;
            return diff < tol;
        endfunction

        function void note_edge(logic [15:0] capture);
            logic [15:0] interval;
            nec_result_t word;
            interval     = capture - prev_capture;
            prev_capture = capture;
            edges_seen++;
            if (!in_frame) begin
                if (in_window(interval, windows[REG_HDR], windows[REG_HDR_TOL]))
                    in_frame = 1'b1;
                return;
            end
            if (in_window(interval, windows[REG_ONE], windows[REG_ONE_TOL])) begin
                frame_word[bit_index] = 1'b1;
            end else if (in_window(interval, windows[REG_ZERO], windows[REG_ZERO_TOL])) begin
                frame_word[bit_index] = 1'b0;
            end else if (in_window(interval, windows[REG_RPT], windows[REG_RPT_TOL])) begin
                in_frame  = 1'b0;
                bit_index = '0;
                word = '{last_address, last_command, 1'b1};
                expected_words.push_back(word);
                return;
            end else begin
                in_frame  = 1'b0;
                bit_index = '0;
                return;
            end
            if (bit_index == FRAME_BITS - 1) begin
                // bytes are kept even when the inverse checks fail
                last_address = frame_word[7:0];
                last_command = frame_word[23:16];
                in_frame     = 1'b0;
                bit_index    = '0;
                if (frame_word[15:8] == ~frame_word[7:0]
                        && frame_word[31:24] == ~frame_word[23:16]) begin
                    word = '{frame_word[7:0], frame_word[23:16], 1'b0};
                    expected_words.push_back(word);
                end
            end else begin
                bit_index++;
            end
        endfunction

        function void check_result(nec_result_t got);
            nec_result_t want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: address %0h command %0h is_repeat %0b",
                       got.address, got.command, got.is_repeat);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.address !== want.address) begin
                $error("address: expected %0h, got %0h", want.address, got.address);
                mismatches++;
            end
            if (got.command !== want.command) begin
                $error("command: expected %0h, got %0h", want.command, got.command);
                mismatches++;
            end
            if (got.is_repeat !== want.is_repeat) begin
                $error("is_repeat: expected %0b, got %0b", want.is_repeat, got.is_repeat);
                mismatches++;
            end
            if (want.is_repeat)
                repeats_seen++;
            else
                frames_seen++;
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    nec_ir_cap_if cap_if ();
    nec_ir_res_if res_if ();

    nec_frame_scoreboard sb = new();
    bit          no_idle     = 1'b0;
    logic [15:0] last_sent   = '0;
    int          items_sent  = 0;
    int          idle_cycles = 0;

    nec_ir_edge_interval_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (cap_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cap_if.valid && cap_if.ready)
                sb.note_edge(cap_if.capture_time);
            if (res_if.valid && res_if.ready)
                sb.check_result('{res_if.address, res_if.command, res_if.is_repeat});
        end
    end

    always @(posedge i_clk) begin
        if ((cap_if.valid && cap_if.ready) || (res_if.valid && res_if.ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            if (no_idle || $urandom_range(0, 3) != 0) begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // setup then access phase; psel stays up across back-to-back writes
    task automatic apb_write(input t_reg_idx idx, input t_cfg_word value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_window(idx, value);
    endtask

    task automatic program_windows(input t_cfg_array w);
        for (int i = 0; i < NUM_REGS; i++)
            apb_write(t_reg_idx'(i), w[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_edge(input int interval);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            cap_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        last_sent = last_sent + 16'(interval);
        cap_if.valid        <= 1'b1;
        cap_if.capture_time <= last_sent;
        do @(posedge i_clk); while (!cap_if.ready);
        items_sent++;
    endtask

    // wait for every expected word, then let the pipeline drain
    task automatic settle();
        cap_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // interval inside a window, or right at its exclusive edge
    function automatic int pick_interval(t_reg_idx nom_reg, bit at_edge);
        int nom, tol, v, lo, hi;
        nom = sb.windows[nom_reg];
        tol = sb.windows[nom_reg + 1];
        if (at_edge) begin
            v = tol - $urandom_range(0, 1);
            v = $urandom_range(0, 1) ? nom + v : nom - v;
            if (v < 0 || v > MAX_TICKS)
                v = $urandom_range(0, MAX_TICKS);
            return v;
        end
        if (tol == 0)
            return $urandom_range(0, MAX_TICKS);
        lo = (nom - tol + 1 < 0) ? 0 : nom - tol + 1;
        hi = (nom + tol - 1 > MAX_TICKS) ? MAX_TICKS : nom + tol - 1;
        return $urandom_range(hi, lo);
    endfunction

    function automatic t_reg_idx any_nominal();
        case ($urandom_range(0, 3))
            0:       return REG_HDR;
            1:       return REG_ONE;
            2:       return REG_ZERO;
            default: return REG_RPT;
        endcase
    endfunction

    function automatic int noise_interval();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, MAX_TICKS);
            1:       return pick_interval(any_nominal(), 1'b1);
            default: return pick_interval(any_nominal(), 1'b0);
        endcase
    endfunction

    task automatic send_repeats(input int count);
        repeat (count) begin
            send_edge(pick_interval(REG_HDR, 1'b0));
            send_edge(pick_interval(REG_RPT, 1'b0));
        end
    endtask

    task automatic run_traffic(input int n_items);
        int          stop_at;
        int          choice;
        logic [31:0] frame;
        t_byte       addr;
        t_byte       cmd;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            choice = $urandom_range(0, 99);
            if (choice < 65) begin
                addr  = t_byte'($urandom);
                cmd   = t_byte'($urandom);
                frame = ($urandom_range(0, 99) < 80) ? {~cmd, cmd, ~addr, addr} : $urandom;
                send_edge(pick_interval(REG_HDR, 1'b0));
                for (int i = 0; i < FRAME_BITS; i++) begin
                    if ($urandom_range(0, 199) == 0)
                        send_edge(noise_interval());
                    send_edge(pick_interval(frame[i] ? REG_ONE : REG_ZERO, 1'b0));
                end
                if ($urandom_range(0, 2) == 0)
                    send_repeats($urandom_range(1, 3));
            end else if (choice < 80) begin
                send_repeats(1);
            end else begin
                repeat ($urandom_range(1, 4)) send_edge(noise_interval());
            end
        end
    endtask

    // runs with the reset windows loaded
    task automatic directed_checks();
        int hdr, hdr_tol, one, one_tol, zero, zero_tol, rpt, rpt_tol;
        hdr      = sb.windows[REG_HDR];
        hdr_tol  = sb.windows[REG_HDR_TOL];
        one      = sb.windows[REG_ONE];
        one_tol  = sb.windows[REG_ONE_TOL];
        zero     = sb.windows[REG_ZERO];
        zero_tol = sb.windows[REG_ZERO_TOL];
        rpt      = sb.windows[REG_RPT];
        rpt_tol  = sb.windows[REG_RPT_TOL];
        // all-ones then all-zeros capture, both ignored outside a frame
        send_edge(MAX_TICKS);
        send_edge(1);
        // repeat before any completed frame carries zero bytes
        send_edge(hdr);
        send_edge(rpt);
        // a header-length interval inside a frame aborts it
        send_edge(hdr + 1500);
        send_edge(hdr + 1500);
        // tolerance is exclusive on both sides
        send_edge(hdr + hdr_tol);
        send_edge(hdr - hdr_tol + 1);
        send_edge(one + one_tol - 1);
        send_edge(zero - zero_tol + 1);
        send_edge(zero - zero_tol);
        // repeat mid-frame, then repeats just outside their window
        send_edge(hdr);
        send_edge(one);
        send_edge(zero);
        send_edge(rpt + rpt_tol - 1);
        send_edge(hdr);
        send_edge(rpt + rpt_tol);
        send_edge(hdr);
        send_edge(rpt - rpt_tol);
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cap_if.valid        <= 1'b0;
        cap_if.capture_time <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_windows(CFG_RESET);
        directed_checks();
        run_traffic(280);
        settle();

        // short intervals, narrow windows
        program_windows('{16'd900, 16'd50, 16'd300, 16'd20, 16'd150, 16'd20, 16'd700, 16'd40});
        run_traffic(230);
        settle();

        // extremes: full-range windows, a single-tick window and an empty one
        program_windows('{16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF,
                          16'hFFFF, 16'd1, 16'h8000, 16'd0});
        run_traffic(90);
        settle();

        // overlapping one, zero and repeat windows exercise match priority
        program_windows('{16'd2100, 16'd300, 16'd2000, 16'd600,
                          16'd1800, 16'd600, 16'd2600, 16'd1000});
        run_traffic(200);
        settle();

        // full throughput to finish
        no_idle = 1'b1;
        program_windows(CFG_RESET);
        run_traffic(200);
        settle();

        $display("covered %0d capture words under 5 window settings", sb.edges_seen);
        $display("checked %0d decoded frames and %0d repeat codes",
                 sb.frames_seen, sb.repeats_seen);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule : nec_ir_edge_interval_decoder_tb

/* sim.f */
hdl/nec_ir_pkg.sv
hdl/nec_ir_ifs.sv
hdl/nec_ir_window.sv
hdl/nec_ir_edge_interval_decoder.sv
verif/nec_ir_edge_interval_decoder_tb.sv
